### rtl/core/mep_pkg.sv
package mep_pkg;

    // Field and datapath widths.
    localparam int COORD_W   = 32;
    localparam int STEP_W    = 31;
    localparam int ITER_W    = 16;
    localparam int PIX_W     = 12;
    localparam int COLOR_W   = 8;
    localparam int FRAC_BITS = 28;
    localparam int PROD_W    = 2 * COORD_W;

    // Squares keep every bit above the binary point of a full product.
    localparam int SQ_W      = PROD_W - FRAC_BITS;
    // Cross term 2*zx*zy is the product shifted by one bit less.
    localparam int CROSS_W   = PROD_W - (FRAC_BITS - 1);
    // Wide sums ahead of saturation.
    localparam int WIDE_W    = 46;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_X_MIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd3;

    // Reset values of the configuration registers.
    localparam logic signed [COORD_W-1:0] X_MIN_RST    = -32'sd671088640;
    localparam logic signed [COORD_W-1:0] Y_MIN_RST    = -32'sd536870912;
    localparam logic [STEP_W-1:0]         STEP_RST     = 31'd2097152;
    localparam logic [ITER_W-1:0]         MAX_ITER_RST = 16'd200;

    // Escape radius squared, 4.0 in the squares' scale.
    localparam logic [SQ_W:0] BAIL = (SQ_W + 1)'(4) << FRAC_BITS;

    localparam logic [COLOR_W-1:0] COLOR_INSIDE  = 8'd0;
    localparam logic [COLOR_W-1:0] COLOR_OUTSIDE = 8'd255;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_min;
        logic signed [COORD_W-1:0] y_min;
        logic [STEP_W-1:0]         pixel_step;
        logic [ITER_W-1:0]         max_iterations;
    } cfg_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [ITER_W-1:0]  iterations;
        logic               in_set;
    } res_t;

    // Clamp a wide signed value to the signed coordinate range.
    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [COORD_W-1:0] r;
        if ((&v[WIDE_W-1:COORD_W-1]) || !(|v[WIDE_W-1:COORD_W-1])) begin
            r = v[COORD_W-1:0];
        end
        else if (v[WIDE_W-1]) begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

### rtl/core/mep_mul.sv
module mep_mul (
    input  logic                                clk,
    input  logic signed [mep_pkg::COORD_W-1:0]  a,
    input  logic signed [mep_pkg::COORD_W-1:0]  b,
    output logic signed [mep_pkg::PROD_W-1:0]   product
);

    logic signed [mep_pkg::PROD_W-1:0] product_reg;

    // Full signed product, registered before any further use.
    always_ff @(posedge clk)
    begin
        product_reg <= mep_pkg::PROD_W'(a) * mep_pkg::PROD_W'(b);
    end

    assign product = product_reg;

endmodule

### rtl/core/mep_core.sv
module mep_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mep_pkg::cfg_t                 cfg,
    input  logic                          pixel_valid,
    output logic                          pixel_ready,
    input  logic [mep_pkg::PIX_W-1:0]     pixel_x,
    input  logic [mep_pkg::PIX_W-1:0]     pixel_y,
    output logic                          res_valid,
    input  logic                          res_ready,
    output mep_pkg::res_t                 res
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MX   = 4'd1;
    localparam logic [3:0] S_MY   = 4'd2;
    localparam logic [3:0] S_CY   = 4'd3;
    localparam logic [3:0] S_ITER = 4'd4;
    localparam logic [3:0] S_ZY   = 4'd5;
    localparam logic [3:0] S_SQX  = 4'd6;
    localparam logic [3:0] S_SQY  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] state_reg, state_next;

    logic [mep_pkg::PIX_W-1:0]           px_reg, px_next;
    logic [mep_pkg::PIX_W-1:0]           py_reg, py_next;
    logic signed [mep_pkg::COORD_W-1:0]  cx_reg, cx_next;
    logic signed [mep_pkg::COORD_W-1:0]  cy_reg, cy_next;
    logic signed [mep_pkg::COORD_W-1:0]  zx_reg, zx_next;
    logic signed [mep_pkg::COORD_W-1:0]  zy_reg, zy_next;
    logic [mep_pkg::SQ_W-1:0]            zx2_reg, zx2_next;
    logic [mep_pkg::SQ_W-1:0]            zy2_reg, zy2_next;
    logic [mep_pkg::ITER_W-1:0]          count_reg, count_next;

    logic signed [mep_pkg::COORD_W-1:0]  mul_a;
    logic signed [mep_pkg::COORD_W-1:0]  mul_b;
    logic signed [mep_pkg::PROD_W-1:0]   product;

    logic signed [mep_pkg::COORD_W-1:0]  step_s;
    logic signed [mep_pkg::WIDE_W-1:0]   cx_sum;
    logic signed [mep_pkg::WIDE_W-1:0]   cy_sum;
    logic signed [mep_pkg::COORD_W-1:0]  cy_sat;
    logic [mep_pkg::COORD_W:0]           cy_ext;
    logic [mep_pkg::COORD_W:0]           cy_abs;
    logic                                cy_small;
    logic signed [mep_pkg::WIDE_W-1:0]   zx_sum;
    logic signed [mep_pkg::WIDE_W-1:0]   zy_sum;
    logic signed [mep_pkg::CROSS_W-1:0]  cross_term;
    logic [mep_pkg::SQ_W:0]              mag;
    logic                                keep_going;
    logic                                at_limit;

    mep_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    // Plane mapping: offset plus pixel index times step, then saturated.
    assign step_s = $signed({1'b0, cfg.pixel_step});
    assign cx_sum = mep_pkg::WIDE_W'(cfg.x_min) + $signed(product[mep_pkg::WIDE_W-1:0]);
    assign cy_sum = mep_pkg::WIDE_W'(cfg.y_min) + $signed(product[mep_pkg::WIDE_W-1:0]);
    assign cy_sat = mep_pkg::sat_coord(cy_sum);

    // The imaginary part snaps to the real axis when within half a step.
    assign cy_ext   = {cy_sat[mep_pkg::COORD_W-1], cy_sat};
    assign cy_abs   = cy_sat[mep_pkg::COORD_W-1] ? (~cy_ext + 1'b1) : cy_ext;
    assign cy_small = {cy_abs, 1'b0} < {3'b000, cfg.pixel_step};

    // Iteration arithmetic. The floor shift is a plain slice of the product.
    assign cross_term = product[mep_pkg::PROD_W-1:mep_pkg::FRAC_BITS-1];
    assign zy_sum = mep_pkg::WIDE_W'(cross_term) + mep_pkg::WIDE_W'(cy_reg);
    assign zx_sum = $signed({{(mep_pkg::WIDE_W-mep_pkg::SQ_W){1'b0}}, zx2_reg})
                  - $signed({{(mep_pkg::WIDE_W-mep_pkg::SQ_W){1'b0}}, zy2_reg})
                  + mep_pkg::WIDE_W'(cx_reg);

    assign mag        = {1'b0, zx2_reg} + {1'b0, zy2_reg};
    assign keep_going = (count_reg < cfg.max_iterations) && (mag < mep_pkg::BAIL);
    assign at_limit   = (count_reg == cfg.max_iterations);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (state_reg)
            S_MX:
            begin
                mul_a = $signed({{(mep_pkg::COORD_W-mep_pkg::PIX_W){1'b0}}, px_reg});
                mul_b = step_s;
            end
            S_MY:
            begin
                mul_a = $signed({{(mep_pkg::COORD_W-mep_pkg::PIX_W){1'b0}}, py_reg});
                mul_b = step_s;
            end
            S_ZY:
            begin
                mul_a = zx_reg;
                mul_b = zx_reg;
            end
            S_SQX:
            begin
                mul_a = zy_reg;
                mul_b = zy_reg;
            end
            default:
            begin
                mul_a = zx_reg;
                mul_b = zy_reg;
            end
        endcase
    end

    // Sequencer: setup, then four steps per iteration around the multiplier.
    always_comb
    begin
        state_next = state_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        zx_next    = zx_reg;
        zy_next    = zy_reg;
        zx2_next   = zx2_reg;
        zy2_next   = zy2_reg;
        count_next = count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pixel_valid)
                begin
                    px_next    = pixel_x;
                    py_next    = pixel_y;
                    state_next = S_MX;
                end
            end
            S_MX:
            begin
                state_next = S_MY;
            end
            S_MY:
            begin
                cx_next    = mep_pkg::sat_coord(cx_sum);
                state_next = S_CY;
            end
            S_CY:
            begin
                cy_next    = cy_small ? '0 : cy_sat;
                zx_next    = '0;
                zy_next    = '0;
                zx2_next   = '0;
                zy2_next   = '0;
                count_next = '0;
                state_next = S_ITER;
            end
            S_ITER:
            begin
                if (keep_going)
                begin
                    zx_next    = mep_pkg::sat_coord(zx_sum);
                    count_next = count_reg + 1'b1;
                    state_next = S_ZY;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_ZY:
            begin
                zy_next    = mep_pkg::sat_coord(zy_sum);
                state_next = S_SQX;
            end
            S_SQX:
            begin
                zx2_next   = product[mep_pkg::PROD_W-1:mep_pkg::FRAC_BITS];
                state_next = S_SQY;
            end
            S_SQY:
            begin
                zy2_next   = product[mep_pkg::PROD_W-1:mep_pkg::FRAC_BITS];
                state_next = S_ITER;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        zx_reg    <= zx_next;
        zy_reg    <= zy_next;
        zx2_reg   <= zx2_next;
        zy2_reg   <= zy2_next;
        count_reg <= count_next;
    end

    assign pixel_ready    = (state_reg == S_IDLE);
    assign res_valid      = (state_reg == S_DONE);
    assign res.color      = at_limit ? mep_pkg::COLOR_INSIDE : mep_pkg::COLOR_OUTSIDE;
    assign res.iterations = count_reg;
    assign res.in_set     = at_limit;

endmodule

### rtl/core/mandelbrot_escape_pixel.sv
// Mandelbrot escape-time evaluator for one pixel at a time.
// Pixel channel: pixel_x and pixel_y with pixel_valid / pixel_ready. An item is
// taken when both are high; pixel_ready is high only while no pixel is in work.
// Result channel: color, iterations and in_set with result_valid / result_ready.
// Configuration: cfg_write_en, cfg_index and cfg_data write x_min, y_min,
// pixel_step and max_iterations (indexes 0 to 3); write them only
// while no pixel is in work and no result is waiting.
// After a pixel is accepted, the core first maps it to the plane and then runs
// the iterations, all on one shared 32x32 multiplier; each iteration forms
// zx*zy, zx*zx and zy*zy on it in turn. A last check then finds the loop
// finished, and the result moves into the output register.
// The core takes a new pixel only after its previous result has left it.
// A finished result sits in an output register; the next pixel is accepted
// while it waits. If the receiver stalls, a second finished result is held in
// the core and pixel_ready stays low until the output register frees up.
// Reset: the configuration returns to x_min -2.5, y_min -2.0, step 4/512 and
// a limit of 200; any pixel in work and any waiting result are dropped.
module mandelbrot_escape_pixel (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [mep_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 pixel_valid,
    output logic                                 pixel_ready,
    input  logic [mep_pkg::PIX_W-1:0]            pixel_x,
    input  logic [mep_pkg::PIX_W-1:0]            pixel_y,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic [mep_pkg::COLOR_W-1:0]          color,
    output logic [mep_pkg::ITER_W-1:0]           iterations,
    output logic                                 in_set
);

    mep_pkg::cfg_t cfg_reg;
    mep_pkg::res_t core_res;
    mep_pkg::res_t res_reg;
    logic          core_valid;
    logic          core_ready;
    logic          result_valid_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_min          <= mep_pkg::X_MIN_RST;
            cfg_reg.y_min          <= mep_pkg::Y_MIN_RST;
            cfg_reg.pixel_step     <= mep_pkg::STEP_RST;
            cfg_reg.max_iterations <= mep_pkg::MAX_ITER_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                mep_pkg::REG_X_MIN:    cfg_reg.x_min <= $signed(cfg_data);
                mep_pkg::REG_Y_MIN:    cfg_reg.y_min <= $signed(cfg_data);
                mep_pkg::REG_STEP:     cfg_reg.pixel_step <= cfg_data[mep_pkg::STEP_W-1:0];
                mep_pkg::REG_MAX_ITER: cfg_reg.max_iterations <= cfg_data[mep_pkg::ITER_W-1:0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    mep_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .res_valid   (core_valid),
        .res_ready   (core_ready),
        .res         (core_res)
    );

    // Output register decouples the receiver from the core.
    assign core_ready = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (core_ready)
        begin
            result_valid_reg <= core_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_ready && core_valid)
        begin
            res_reg <= core_res;
        end
    end

    assign result_valid = result_valid_reg;
    assign color        = res_reg.color;
    assign iterations   = res_reg.iterations;
    assign in_set       = res_reg.in_set;

    // The in-set flag agrees with the count against the current limit.
    a_inset_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (in_set == (iterations == cfg_reg.max_iterations)))
        else $error("in_set disagrees with iteration count");

    // The count never passes the limit.
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (iterations <= cfg_reg.max_iterations))
        else $error("iteration count above limit");

    // Color follows the in-set flag.
    a_color: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (in_set ? (color == mep_pkg::COLOR_INSIDE)
                                 : (color == mep_pkg::COLOR_OUTSIDE)))
        else $error("color disagrees with in_set");

    // A pixel is never taken while the core still holds a finished result.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        core_valid |-> !pixel_ready)
        else $error("pixel accepted while core busy");

endmodule
